// File: rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks, detail_edge_remap.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/dera_pkg.sv
// Types, constants and table-building functions of the detail/edge remap block.
package dera_pkg;

  localparam int unsigned PIX_W  = 16;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned REG_W  = 16;
  localparam int unsigned IDX_W  = 2;

  // Lower edge of the smoothstep interval; the upper edge is twice this.
  localparam logic [PIX_W-1:0] SMOOTH_LO = PIX_W'((1 << PIX_W) / 100);

  // Reciprocal of SMOOTH_LO, rounded up; (x * SMOOTH_RECIP) >> SMOOTH_SHIFT
  // equals floor(x * 2^FRAC_W / SMOOTH_LO) for every x below SMOOTH_LO.
  localparam int unsigned SMOOTH_SHIFT = 20;
  localparam logic [26:0] SMOOTH_RECIP =
    27'(((64'd1 << (FRAC_W + SMOOTH_SHIFT)) + 64'(SMOOTH_LO) - 64'd1) / 64'(SMOOTH_LO));

  localparam logic [REG_W-1:0] SIGMA_RESET = 16'd26214;
  localparam logic [REG_W-1:0] ALPHA_RESET = 16'd1024;
  localparam logic [REG_W-1:0] BETA_RESET  = 16'd4096;
  localparam logic [REG_W-1:0] ALPHA_ONE   = 16'd4096;

  typedef enum logic [IDX_W-1:0] {
    REG_RANGE_SIGMA = 2'd0,
    REG_DETAIL_EXP  = 2'd1,
    REG_EDGE_GAIN   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [PIX_W-1:0] reference_value;
    logic             outside_image;
    logic             last_in_window;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] remapped_value;
    logic             clipped;
    logic             window_end;
  } out_item_t;

  // Integer square root, bit by bit.
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'h1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (b > n) b = b >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // log2 of a Q30 value in [1,2], Q30 result, by repeated squaring.
  function automatic logic [63:0] log2_q30(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] y;
    x = x_in;
    y = '0;
    if (x >= 64'h8000_0000) return 64'h4000_0000;
    for (int b = 1; b <= 30; b++) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        y = y | (64'h1 << (30 - b));
      end
    end
    return y;
  endfunction

  // Log table entry, Q16, from a Q30 argument.
  function automatic logic [16:0] log_entry(input logic [63:0] x);
    logic [63:0] t;
    t = log2_q30(x) + 64'd8192;
    return 17'(t >> 14);
  endfunction

  // Exp2 table entry, Q16, from a Q30 fraction.
  function automatic logic [17:0] exp_entry(input logic [63:0] u);
    logic [63:0] roots [30];
    logic [63:0] acc;
    roots[0] = isqrt64(64'h2 << 60);
    for (int b = 1; b < 30; b++) roots[b] = isqrt64(roots[b-1] << 30);
    acc = 64'h4000_0000;
    for (int b = 0; b < 30; b++) begin
      if (((u >> (29 - b)) & 64'h1) != 0) acc = (acc * roots[b]) >> 30;
    end
    return 18'((acc + 64'd8192) >> 14);
  endfunction

endpackage

// File: rtl/dera_divider.sv
// Pipelined restoring divider: one quotient bit per stage, numerator below divisor.
module dera_divider
  import dera_pkg::*;
#(
  parameter int unsigned W = 16
) (
  input  logic         clk,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] quo
);

  logic [W-1:0] rem_q [W-1];
  logic [W-1:0] den_q [W-1];
  logic [W-1:0] quo_q [W];

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W-1:0] rem_in;
    logic [W-1:0] den_in;
    logic [W-1:0] quo_in;
    logic [W:0]   trial;
    logic         fits;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // shift in a zero and try the subtract
    assign trial = {rem_in, 1'b0};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      quo_q[i] <= {quo_in[W-2:0], fits};
    end

    if (i < W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[i] <= fits ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
        den_q[i] <= den_in;
      end
    end
  end

  assign quo = quo_q[W-1];

endmodule

// File: rtl/detail_edge_remap.sv
// Top level of the per-pixel detail/edge remap pipeline.
//
// One pixel enters on every clock at which start is high; busy is always low,
// so the block never refuses a pixel. Each result is shown for one cycle
// with done high; the receiver cannot stall it, and the pipeline never stalls.
// Each pixel passes through the input register, the 16-stage pipelined divider
// for f = d/sigma (the smoothstep position, a division by a constant, is a
// reciprocal multiply that runs alongside it), eleven stages of log/exp table
// lookup, interpolation, power and blend, the sign and saturation logic, and
// the output register. Register writes take effect at once; the user must make
// them only while the pipeline is empty, as the block itself does not enforce
// this. The log and exp tables are constants fixed at elaboration, so reset
// needs no fill pass.
module detail_edge_remap
  import dera_pkg::*;
#(
  parameter int unsigned POW_TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         item,
  output logic             done,
  output out_item_t        result,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0] wr_data
);

  `include "assert_macros.svh"

  localparam int unsigned D       = POW_TABLE_DEPTH;
  localparam int unsigned IW      = $clog2(D + 1);
  localparam int unsigned JW      = $clog2(D);
  localparam int unsigned PW      = FRAC_W + JW;
  localparam int unsigned NPOST   = 11;
  localparam int unsigned LATENCY = FRAC_W + 13;

  typedef struct packed {
    logic [PIX_W-1:0]  r;
    logic [PIX_W-1:0]  d;
    logic              neg;
    logic              outside;
    logic              last;
    logic              detail;
    logic              lo_sel;
    logic              hi_sel;
    logic [FRAC_W-1:0] f;
  } side_t;

  // configuration registers
  logic [REG_W-1:0] sigma;
  logic [REG_W-1:0] alpha;
  logic [REG_W-1:0] beta;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma <= SIGMA_RESET;
      alpha <= ALPHA_RESET;
      beta  <= BETA_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RANGE_SIGMA: sigma <= wr_data;
        REG_DETAIL_EXP:  alpha <= wr_data;
        REG_EDGE_GAIN:   beta  <= wr_data;
        default: ;
      endcase
    end
  end

  // constant log and exp tables
  logic [16:0] log_rom [D+1];
  logic [17:0] exp_rom [D+1];

  for (genvar i = 0; i <= D; i++) begin : g_rom
    localparam logic [63:0] XL = ((64'(D) + 64'(i)) << 30) / 64'(D);
    localparam logic [63:0] XU = (64'(i) << 30) / 64'(D);
    localparam logic [16:0] LV = log_entry(XL);
    localparam logic [17:0] EV = (i == D) ? 18'h20000 : exp_entry(XU);
    assign log_rom[i] = LV;
    assign exp_rom[i] = EV;
  end

  assign busy = 1'b0;

  // input register
  logic     in_vld;
  in_item_t in_q;

  always_ff @(posedge clk) begin
    if (rst) in_vld <= 1'b0;
    else     in_vld <= start && !busy;
  end

  always_ff @(posedge clk) begin
    in_q <= item;
  end

  // distance, sign, branch and smoothstep interval
  side_t             side_a;
  logic [PIX_W-1:0]  div_num;

  always_comb begin
    side_a         = '0;
    side_a.r       = in_q.reference_value;
    side_a.neg     = in_q.pixel_value < in_q.reference_value;
    side_a.d       = side_a.neg ? PIX_W'(in_q.reference_value - in_q.pixel_value)
                                : PIX_W'(in_q.pixel_value - in_q.reference_value);
    side_a.outside = in_q.outside_image;
    side_a.last    = in_q.last_in_window;
    side_a.detail  = side_a.d < sigma;
    side_a.lo_sel  = side_a.d <= SMOOTH_LO;
    side_a.hi_sel  = {1'b0, side_a.d} >= {SMOOTH_LO, 1'b0};
    div_num        = side_a.detail ? side_a.d : '0;
  end

  // divider: f = d/sigma
  logic [FRAC_W-1:0] quo_f;

  dera_divider #(.W(FRAC_W)) u_div_f (
    .clk (clk),
    .num (div_num),
    .den (sigma),
    .quo (quo_f)
  );

  // side data that walks alongside the divider stages
  side_t             side_d [FRAC_W];
  logic [FRAC_W-1:0] vld_d;

  for (genvar i = 0; i < FRAC_W; i++) begin : g_side_d
    if (i == 0) begin : g_first
      always_ff @(posedge clk) side_d[i] <= side_a;
      always_ff @(posedge clk) begin
        if (rst) vld_d[i] <= 1'b0;
        else     vld_d[i] <= in_vld;
      end
    end else begin : g_rest
      always_ff @(posedge clk) side_d[i] <= side_d[i-1];
      always_ff @(posedge clk) begin
        if (rst) vld_d[i] <= 1'b0;
        else     vld_d[i] <= vld_d[i-1];
      end
    end
  end

  // smoothstep position y = (d - lo)/lo by reciprocal multiply, lands with quo_f
  logic [PIX_W-1:0]  sm_off;
  logic [FRAC_W-1:0] quo_y;

  assign sm_off = (!side_d[FRAC_W-2].lo_sel && !side_d[FRAC_W-2].hi_sel)
                ? PIX_W'(side_d[FRAC_W-2].d - SMOOTH_LO) : '0;

  always_ff @(posedge clk) begin
    quo_y <= FRAC_W'((43'(sm_off) * 43'(SMOOTH_RECIP)) >> SMOOTH_SHIFT);
  end

  // side data of the post-divider stages
  side_t            side_p [NPOST];
  logic [NPOST-1:0] vld_p;
  side_t            side_p0_next;

  always_comb begin
    side_p0_next   = side_d[FRAC_W-1];
    side_p0_next.f = quo_f;
  end

  for (genvar i = 0; i < NPOST; i++) begin : g_side_p
    if (i == 0) begin : g_first
      always_ff @(posedge clk) side_p[i] <= side_p0_next;
      always_ff @(posedge clk) begin
        if (rst) vld_p[i] <= 1'b0;
        else     vld_p[i] <= vld_d[FRAC_W-1];
      end
    end else begin : g_rest
      always_ff @(posedge clk) side_p[i] <= side_p[i-1];
      always_ff @(posedge clk) begin
        if (rst) vld_p[i] <= 1'b0;
        else     vld_p[i] <= vld_p[i-1];
      end
    end
  end

  // P1: leading one and mantissa of f; y squared
  logic [3:0]        k_next;
  logic [FRAC_W-1:0] m_next;
  logic [3:0]        p1_k;
  logic [FRAC_W-1:0] p1_m;
  logic [15:0]       p1_y2;
  logic [17:0]       p1_t;

  always_comb begin
    k_next = '0;
    for (int b = 1; b < FRAC_W; b++) begin
      if (quo_f[b]) k_next = 4'(b);
    end
    m_next = FRAC_W'(32'(quo_f) << (5'd16 - {1'b0, k_next}));
  end

  always_ff @(posedge clk) begin
    p1_k  <= k_next;
    p1_m  <= m_next;
    p1_y2 <= 16'((32'(quo_y) * 32'(quo_y)) >> 16);
    p1_t  <= 18'h20000 - 18'(quo_y);
  end

  // P2: log table position; (2 - y) squared
  logic [PW-1:0]  pos_l;
  logic [JW-1:0]  p2_j;
  logic [15:0]    p2_q;
  logic [3:0]     p2_k;
  logic [15:0]    p2_y2;
  logic [18:0]    p2_t2;

  assign pos_l = PW'(p1_m) * PW'(D);

  always_ff @(posedge clk) begin
    p2_j  <= pos_l[PW-1:16];
    p2_q  <= pos_l[15:0];
    p2_k  <= p1_k;
    p2_y2 <= p1_y2;
    p2_t2 <= 19'((36'(p1_t) * 36'(p1_t)) >> 16);
  end

  // P3: log table read; smoothstep weight
  logic [16:0] p3_l0;
  logic [16:0] p3_l1;
  logic [15:0] p3_q;
  logic [3:0]  p3_k;
  logic [16:0] p3_b;
  logic [16:0] b_next;

  always_comb begin
    priority if (side_p[1].lo_sel) b_next = '0;
    else if (side_p[1].hi_sel)     b_next = 17'h10000;
    else                           b_next = 17'((35'(p2_y2) * 35'(p2_t2)) >> 16);
  end

  always_ff @(posedge clk) begin
    p3_l0 <= log_rom[IW'(p2_j)];
    p3_l1 <= log_rom[IW'(p2_j) + IW'(1)];
    p3_q  <= p2_q;
    p3_k  <= p2_k;
    p3_b  <= b_next;
  end

  // P4: interpolated log, negated log2 of f
  logic [16:0] lm;
  logic [20:0] p4_nl;
  logic [16:0] p4_b;

  assign lm = 17'(p3_l0 + 17'((33'(p3_l1 - p3_l0) * 33'(p3_q)) >> 16));

  always_ff @(posedge clk) begin
    p4_nl <= (21'(5'd16 - {1'b0, p3_k}) << 16) - 21'(lm);
    p4_b  <= p3_b;
  end

  // P5: scale by alpha
  logic [24:0] e_next;
  logic [8:0]  p5_ip;
  logic [15:0] p5_fp;
  logic [16:0] p5_b;

  assign e_next = 25'((37'(p4_nl) * 37'(alpha)) >> 12);

  always_ff @(posedge clk) begin
    p5_ip <= e_next[24:16];
    p5_fp <= e_next[15:0];
    p5_b  <= p4_b;
  end

  // P6: exp table position
  logic [15:0]   u_next;
  logic [PW-1:0] pos_e;
  logic [JW-1:0] p6_j;
  logic [15:0]   p6_q;
  logic [8:0]    p6_ip;
  logic          p6_fp0;
  logic [16:0]   p6_b;

  assign u_next = 16'(17'h10000 - {1'b0, p5_fp});
  assign pos_e  = PW'(u_next) * PW'(D);

  always_ff @(posedge clk) begin
    p6_j   <= pos_e[PW-1:16];
    p6_q   <= pos_e[15:0];
    p6_ip  <= p5_ip;
    p6_fp0 <= p5_fp == '0;
    p6_b   <= p5_b;
  end

  // P7: exp table read
  logic [17:0] p7_e0;
  logic [17:0] p7_e1;
  logic [15:0] p7_q;
  logic [8:0]  p7_ip;
  logic        p7_fp0;
  logic [16:0] p7_b;

  always_ff @(posedge clk) begin
    p7_e0  <= exp_rom[IW'(p6_j)];
    p7_e1  <= exp_rom[IW'(p6_j) + IW'(1)];
    p7_q   <= p6_q;
    p7_ip  <= p6_ip;
    p7_fp0 <= p6_fp0;
    p7_b   <= p6_b;
  end

  // P8: interpolated exp and final shift give f^alpha
  logic [17:0] rr;
  logic [16:0] p_next;
  logic [16:0] p8_p;
  logic [16:0] p8_b;

  always_comb begin
    rr = 18'(p7_e0 + 18'((36'(p7_e1 - p7_e0) * 36'(p7_q)) >> 16));
    priority if (side_p[6].f == '0) p_next = '0;
    else if (p7_ip > 9'd16)         p_next = '0;
    else if (p7_fp0)                p_next = 17'(17'h10000 >> p7_ip[4:0]);
    else                            p_next = 17'(rr >> (p7_ip[4:0] + 5'd1));
  end

  always_ff @(posedge clk) begin
    p8_p <= p_next;
    p8_b <= p7_b;
  end

  // P9: blend products; edge slope product
  logic [33:0] p9_bp;
  logic [32:0] p9_bf;
  logic [16:0] p9_p;
  logic [31:0] p9_eprod;

  always_ff @(posedge clk) begin
    p9_bp    <= 34'(p8_b) * 34'(p8_p);
    p9_bf    <= 33'(17'h10000 - p8_b) * 33'(side_p[7].f);
    p9_p     <= p8_p;
    p9_eprod <= 32'(beta) * 32'(PIX_W'(side_p[7].d - sigma));
  end

  // P10: blended power; edge magnitude
  logic [34:0] blend_sum;
  logic [16:0] p10_pb;
  logic [20:0] p10_emag;

  assign blend_sum = 35'(p9_bp) + 35'(p9_bf);

  always_ff @(posedge clk) begin
    p10_pb   <= (alpha < ALPHA_ONE) ? 17'(blend_sum >> 16) : p9_p;
    p10_emag <= 21'(p9_eprod >> 12) + 21'(sigma);
  end

  // P11: detail magnitude and branch select
  logic [16:0] dmag;
  logic [20:0] p11_mag;

  assign dmag = 17'((33'(sigma) * 33'(p10_pb)) >> 16);

  always_ff @(posedge clk) begin
    p11_mag <= side_p[9].detail ? 21'(dmag) : p10_emag;
  end

  // apply sign around the reference and saturate
  out_item_t  res_next;
  logic [21:0] up_sum;

  always_comb begin
    res_next            = '0;
    res_next.window_end = side_p[10].last;
    up_sum              = 22'(side_p[10].r) + 22'(p11_mag);
    priority if (side_p[10].outside) begin
      res_next.remapped_value = '0;
    end else if (side_p[10].neg) begin
      if (p11_mag > 21'(side_p[10].r)) begin
        res_next.clipped = 1'b1;
      end else begin
        res_next.remapped_value = PIX_W'(21'(side_p[10].r) - p11_mag);
      end
    end else begin
      if (up_sum > 22'({PIX_W{1'b1}})) begin
        res_next.remapped_value = '1;
        res_next.clipped        = 1'b1;
      end else begin
        res_next.remapped_value = up_sum[PIX_W-1:0];
      end
    end
  end

  // output register and strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld_p[NPOST-1];
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  // checks
  logic res_at_rail;

  assign res_at_rail = (result.remapped_value == '0) || (result.remapped_value == '1);

  `ASSERT_IMPLIES(a_fixed_latency, clk, rst, start && !busy, ##LATENCY done)
  `ASSERT_IMPLIES(a_clip_at_rail, clk, rst, done && result.clipped, res_at_rail)
  `ASSERT_NEXT(a_detail_bound, clk, rst, vld_p[9] && side_p[9].detail, p11_mag <= 21'(sigma))

endmodule
